FILE: src/mpr_pkg.sv
package mpr_pkg;

    localparam int PACKET_BYTES = 12;
    localparam int SCAN_POS     = PACKET_BYTES - 5;
    localparam int BYTE_CNT_W   = $clog2(PACKET_BYTES);
    localparam int SCAN_W       = $clog2(SCAN_POS + 1);
    localparam int TICK_W       = 17;
    localparam int TIMEOUT_W    = 16;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [TICK_W-1:0]    TICK_MAX      = {TICK_W{1'b1}};
    localparam logic [3:0]           SYNC_NIBBLE   = 4'hF;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_BYTE  = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ERR_OK      = 2'd0,
        ERR_TIMEOUT = 2'd1,
        ERR_NO_SYNC = 2'd2
    } err_t;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] rx_byte;
    } in_t;

    typedef struct packed {
        logic [1:0]  error_code;
        logic [3:0]  function_code;
        logic [2:0]  scale_code;
        logic [2:0]  decimal_places;
        logic [15:0] status_word;
        logic [14:0] magnitude;
        logic        negative;
    } out_t;

endpackage

FILE: src/meter_packet_receiver.sv
// Channel   | Signals                       | Direction | Beat
// ----------+-------------------------------+-----------+------------------------------
// input     | in_valid, in_stall, in_data   | in        | command + rx_byte
// result    | out_valid, out_stall, out_data| out       | error and decoded fields
// config    | cfg_we, cfg_data              | in        | timeout_ticks write
//
// Start, tick and ordinary byte beats add no stall of their own. The last byte of a
// packet starts a scan along the cell chain, one position per cycle, until a sync
// hit or the last scan position, where it waits for the output register to be free;
// in_stall is high during the scan.
// Reset (rst_n, asynchronous) leaves the receiver idle, counts cleared and the
// timeout at 1000 ticks; the byte cells hold no reset.
// A result sits in the output register until taken; input stalls whenever a
// held result is stalled, whatever the next beat is, as well as during the scan.
module meter_packet_receiver (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  mpr_pkg::in_t                  in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output mpr_pkg::out_t                 out_data,
    input  logic                          cfg_we,
    input  logic [mpr_pkg::TIMEOUT_W-1:0] cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RECV,
        ST_SCAN
    } state_t;

    state_t                            state_reg,     state_next;
    logic [mpr_pkg::BYTE_CNT_W-1:0]    byte_cnt_reg,  byte_cnt_next;
    logic [mpr_pkg::TICK_W-1:0]        tick_cnt_reg,  tick_cnt_next;
    logic [mpr_pkg::SCAN_W-1:0]        scan_idx_reg,  scan_idx_next;
    logic [mpr_pkg::TIMEOUT_W-1:0]     timeout_reg,   timeout_next;
    logic                              out_valid_reg, out_valid_next;
    mpr_pkg::out_t                     out_data_reg,  out_data_next;

    logic                              in_accept;
    logic                              out_free;
    logic                              shift_en;
    logic [mpr_pkg::TICK_W-1:0]        tick_inc;
    logic [7:0]                        cell_q [mpr_pkg::PACKET_BYTES];
    logic [15:0]                       head_word;
    logic [15:0]                       stat_word;
    logic [15:0]                       val_word;
    logic                              sync_hit;
    mpr_pkg::out_t                     decoded;
    mpr_pkg::out_t                     err_result;

    // Output register may be loaded when empty or being emptied this cycle.
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg == ST_SCAN) || !out_free;
    assign in_accept = in_valid && !in_stall;

    // Byte chain: new bytes enter at the top cell and move towards cell 0.
    // After a full packet cell k holds byte k; each scan step moves every
    // byte down one place, so the decode window is always cells 0..5.
    generate
        for (genvar k = 0; k < mpr_pkg::PACKET_BYTES; k++)
        begin : g_cell
            if (k == mpr_pkg::PACKET_BYTES - 1)
            begin : g_top
                mpr_cell u_cell (
                    .clk      (clk),
                    .shift_en (shift_en),
                    .d        (in_data.rx_byte),
                    .q        (cell_q[k])
                );
            end
            else
            begin : g_mid
                mpr_cell u_cell (
                    .clk      (clk),
                    .shift_en (shift_en),
                    .d        (cell_q[k+1]),
                    .q        (cell_q[k])
                );
            end
        end
    endgenerate

    // Window decode: byte 1 is the candidate sync byte (high of header).
    assign head_word = {cell_q[1], cell_q[0]};
    assign stat_word = {cell_q[3], cell_q[2]};
    assign val_word  = {cell_q[5], cell_q[4]};
    assign sync_hit  = (cell_q[1][7:4] == mpr_pkg::SYNC_NIBBLE);

    always_comb
    begin
        decoded                = '0;
        decoded.error_code     = mpr_pkg::ERR_OK;
        decoded.function_code  = head_word[9:6];
        decoded.scale_code     = head_word[5:3];
        decoded.decimal_places = head_word[2:0];
        decoded.status_word    = stat_word;
        decoded.magnitude      = val_word[14:0];
        // 0x7fff or above: top bit set, or the low fifteen bits all ones
        decoded.negative       = val_word[15] || (&val_word[14:0]);
    end

    assign tick_inc = (tick_cnt_reg == mpr_pkg::TICK_MAX) ? tick_cnt_reg
                                                          : tick_cnt_reg + 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        byte_cnt_next  = byte_cnt_reg;
        tick_cnt_next  = tick_cnt_reg;
        scan_idx_next  = scan_idx_reg;
        timeout_next   = cfg_we ? cfg_data : timeout_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        shift_en       = 1'b0;
        err_result     = '0;

        unique case (state_reg)
            ST_IDLE, ST_RECV:
            begin
                if (in_accept)
                begin
                    unique case (in_data.command)
                        mpr_pkg::CMD_START:
                        begin
                            state_next    = ST_RECV;
                            byte_cnt_next = '0;
                            tick_cnt_next = '0;
                        end
                        mpr_pkg::CMD_BYTE:
                        begin
                            if (state_reg == ST_RECV)
                            begin
                                shift_en = 1'b1;
                                if (byte_cnt_reg ==
                                    mpr_pkg::BYTE_CNT_W'(mpr_pkg::PACKET_BYTES - 1))
                                begin
                                    state_next    = ST_SCAN;
                                    byte_cnt_next = '0;
                                    scan_idx_next = '0;
                                end
                                else
                                begin
                                    byte_cnt_next = byte_cnt_reg + 1'b1;
                                end
                            end
                        end
                        mpr_pkg::CMD_TICK:
                        begin
                            if (state_reg == ST_RECV)
                            begin
                                tick_cnt_next = tick_inc;
                                if (tick_inc > {1'b0, timeout_reg})
                                begin
                                    err_result.error_code = mpr_pkg::ERR_TIMEOUT;
                                    out_data_next         = err_result;
                                    out_valid_next        = 1'b1;
                                    state_next            = ST_IDLE;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (sync_hit)
                begin
                    if (out_free)
                    begin
                        out_data_next  = decoded;
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else if (scan_idx_reg == mpr_pkg::SCAN_W'(mpr_pkg::SCAN_POS - 1))
                begin
                    if (out_free)
                    begin
                        err_result.error_code = mpr_pkg::ERR_NO_SYNC;
                        out_data_next         = err_result;
                        out_valid_next        = 1'b1;
                        state_next            = ST_IDLE;
                    end
                end
                else
                begin
                    shift_en      = 1'b1;
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            byte_cnt_reg  <= '0;
            tick_cnt_reg  <= '0;
            scan_idx_reg  <= '0;
            timeout_reg   <= mpr_pkg::TIMEOUT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            byte_cnt_reg  <= byte_cnt_next;
            tick_cnt_reg  <= tick_cnt_next;
            scan_idx_reg  <= scan_idx_next;
            timeout_reg   <= timeout_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: src/mpr_cell.sv
// One byte of the packet chain; takes its neighbour's byte when shifted.
module mpr_cell (
    input  logic       clk,
    input  logic       shift_en,
    input  logic [7:0] d,
    output logic [7:0] q
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    assign byte_next = shift_en ? d : byte_reg;
    assign q         = byte_reg;

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

endmodule
